// ===== hw/rtl/texture_sampler_tile_modes_defines.svh =====
// ----------------------------------------------------------------------------
// Texture sampler assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_SAMPLER_TILE_MODES_DEFINES_SVH
`define TEXTURE_SAMPLER_TILE_MODES_DEFINES_SVH

// same-cycle implication, reset masked
`define TSM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("texture sampler check failed");

// next-cycle implication, reset masked
`define TSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("texture sampler check failed");

`endif

// ===== hw/rtl/tsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Texture sampler package
// Defaults, register indexes and codes for the nearest texel sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package tsm_pkg;

	localparam int MAX_DIM_DEF    = 256;
	localparam int COORD_BITS_DEF = 12;

	// Q16.17 after the half-pixel doubling
	localparam int FRAC_SHIFT = 17;
	// remainder bits resolved per divider stage
	localparam int DIV_STEPS  = 8;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_SX     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_KX     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_TX     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_KY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_SY     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_TY     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_SIZE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SHADE_CTRL = 3'd7;

	localparam logic [1:0] MODE_CLAMP  = 2'd0;
	localparam logic [1:0] MODE_REPEAT = 2'd1;
	localparam logic [1:0] MODE_MIRROR = 2'd2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SHADE = 1'b1;

	localparam logic [8:0] ALPHA_ONE = 9'd256;

	localparam logic [31:0] MAP_UNIT = 32'h0001_0000;

endpackage

`default_nettype wire

// ===== hw/rtl/texture_sampler_tile_modes.sv =====
// ----------------------------------------------------------------------------
// Nearest texel sampler with clamp, repeat and mirror tiling
// Affine map of pixel centers, tile fold, texel fetch and alpha scaling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes write items, which load one texel
//   at column coord_x, row coord_y, and shade items, which map the device
//   pixel (coord_x, coord_y) into the texture and return one pixel_argb on
//   the output channel (out_valid/out_stall). Writes give no output.
//   The configuration channel (cfg_valid/cfg_ready, always ready) writes the
//   registers; write them only while the pipeline is empty.
//   Throughput: one item per cycle while no valid output is stalled.
//   The fold remainder by width or height is resolved in
//   DS = ceil((COORD_BITS + 19) / 8) remainder stages, 8 bits per stage.
//   Items are kept in order; writes reach the texel store at the same stage
//   where shade items read it, so a shade sees every earlier write.
//   Reset empties the pipeline and loads the identity map, full 256x256
//   size, clamp mode and unit alpha; the texel store is not cleared.
//   While the receiver stalls a valid output, the whole pipeline holds and
//   in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_sampler_tile_modes #(
	parameter int MAX_DIM    = tsm_pkg::MAX_DIM_DEF,
	parameter int COORD_BITS = tsm_pkg::COORD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           command,
	input  wire logic [COORD_BITS-1:0]          coord_x,
	input  wire logic [COORD_BITS-1:0]          coord_y,
	input  wire logic [31:0]                    texel_value,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [31:0]                         pixel_argb,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                    cfg_data
);

	localparam int HW    = COORD_BITS + 2;
	localparam int PW    = 32 + HW;
	localparam int SW    = PW + 2;
	localparam int KW    = SW - tsm_pkg::FRAC_SHIFT;
	localparam int DS    = (KW + tsm_pkg::DIV_STEPS - 1) / tsm_pkg::DIV_STEPS;
	localparam int MW    = DS * tsm_pkg::DIV_STEPS;
	localparam int NW    = ($clog2(MAX_DIM + 1) > 9) ? $clog2(MAX_DIM + 1) : 9;
	localparam int RW    = NW + 1;
	localparam int DB    = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int MS    = DS + 4;
	localparam int LS    = DS + 6;

	// configuration
	logic signed [31:0] map_sx_q, map_kx_q, map_tx_q, map_ky_q, map_sy_q, map_ty_q;
	logic [15:0]        size_q;
	logic [10:0]        ctrl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_sx_q <= tsm_pkg::MAP_UNIT;
			map_kx_q <= '0;
			map_tx_q <= '0;
			map_ky_q <= '0;
			map_sy_q <= tsm_pkg::MAP_UNIT;
			map_ty_q <= '0;
			size_q   <= 16'hFFFF;
			ctrl_q   <= 11'(tsm_pkg::ALPHA_ONE);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tsm_pkg::REG_MAP_SX:     map_sx_q <= cfg_data;
				tsm_pkg::REG_MAP_KX:     map_kx_q <= cfg_data;
				tsm_pkg::REG_MAP_TX:     map_tx_q <= cfg_data;
				tsm_pkg::REG_MAP_KY:     map_ky_q <= cfg_data;
				tsm_pkg::REG_MAP_SY:     map_sy_q <= cfg_data;
				tsm_pkg::REG_MAP_TY:     map_ty_q <= cfg_data;
				tsm_pkg::REG_TEX_SIZE:   size_q   <= cfg_data[15:0];
				tsm_pkg::REG_SHADE_CTRL: ctrl_q   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// derived sizes and modes
	logic [NW-1:0] w_raw, h_raw, w_n, h_n;
	logic [1:0]    mode;
	logic          mirror;
	logic [RW-1:0] m_u, m_v;
	logic [8:0]    alpha;

	always_comb begin
		w_raw  = NW'(size_q[7:0]) + NW'(1);
		h_raw  = NW'(size_q[15:8]) + NW'(1);
		w_n    = (w_raw > NW'(MAX_DIM)) ? NW'(MAX_DIM) : w_raw;
		h_n    = (h_raw > NW'(MAX_DIM)) ? NW'(MAX_DIM) : h_raw;
		mode   = ctrl_q[10:9];
		mirror = mode[1];
		m_u    = mirror ? {w_n, 1'b0} : {1'b0, w_n};
		m_v    = mirror ? {h_n, 1'b0} : {1'b0, h_n};
		alpha  = (ctrl_q[8:0] > tsm_pkg::ALPHA_ONE) ? tsm_pkg::ALPHA_ONE : ctrl_q[8:0];
	end

	// global advance
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// item tags traveling with the data
	logic          vld_s   [1:LS];
	logic          shd_s   [1:LS];
	logic          wen_s   [1:MS];
	logic [AW-1:0] waddr_s [1:MS];
	logic [31:0]   wdata_s [1:MS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LS; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= LS; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	logic          wr_in_range;
	logic [AW-1:0] wr_addr_d;

	assign wr_in_range = (32'(coord_x) < 32'(MAX_DIM)) && (32'(coord_y) < 32'(MAX_DIM));
	assign wr_addr_d   = AW'(32'(coord_y) * 32'(MAX_DIM) + 32'(coord_x));

	always_ff @(posedge clk) begin
		if (adv) begin
			shd_s[1]   <= (command == tsm_pkg::CMD_SHADE);
			wen_s[1]   <= (command == tsm_pkg::CMD_WRITE) && wr_in_range;
			waddr_s[1] <= wr_addr_d;
			wdata_s[1] <= texel_value;
			for (int i = 2; i <= LS; i++) shd_s[i] <= shd_s[i-1];
			for (int i = 2; i <= MS; i++) begin
				wen_s[i]   <= wen_s[i-1];
				waddr_s[i] <= waddr_s[i-1];
				wdata_s[i] <= wdata_s[i-1];
			end
		end
	end

	// stage 1: products with the doubled pixel center 2x+1, 2y+1
	logic signed [HW-1:0] hx_d, hy_d;
	logic signed [PW-1:0] pux_s1, puy_s1, pvx_s1, pvy_s1;
	logic signed [32:0]   tu_s1, tv_s1;

	assign hx_d = {1'b0, coord_x, 1'b1};
	assign hy_d = {1'b0, coord_y, 1'b1};

	always_ff @(posedge clk) begin
		if (adv) begin
			pux_s1 <= map_sx_q * hx_d;
			puy_s1 <= map_kx_q * hy_d;
			pvx_s1 <= map_ky_q * hx_d;
			pvy_s1 <= map_sy_q * hy_d;
			tu_s1  <= {map_tx_q, 1'b0};
			tv_s1  <= {map_ty_q, 1'b0};
		end
	end

	// stage 2: sums with 17 fraction bits (Q31.17 at the default COORD_BITS)
	logic signed [SW-1:0] u_s2, v_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s2 <= SW'(pux_s1) + SW'(puy_s1) + SW'(tu_s1);
			v_s2 <= SW'(pvx_s1) + SW'(pvy_s1) + SW'(tv_s1);
		end
	end

	// stage 3: floor, magnitude for the remainder, clamp result
	function automatic logic [DB-1:0] clamp_ix(input logic neg, input logic [MW-1:0] mag,
			input logic [NW-1:0] n);
		logic [DB-1:0] r;
		if (neg)
			r = '0;
		else if (mag >= MW'(n))
			r = DB'(n - NW'(1));
		else
			r = mag[DB-1:0];
		return r;
	endfunction

	function automatic logic [RW-1:0] rem_step(input logic [RW-1:0] rem, input logic b,
			input logic [RW-1:0] m);
		logic [RW:0] t;
		t = {rem, b};
		if (t >= {1'b0, m})
			t = t - {1'b0, m};
		return t[RW-1:0];
	endfunction

	logic [RW-1:0] u_rem_s [0:DS];
	logic [RW-1:0] v_rem_s [0:DS];
	logic [MW-1:0] u_mag_s [0:DS];
	logic [MW-1:0] v_mag_s [0:DS];
	logic          u_neg_s [0:DS];
	logic          v_neg_s [0:DS];
	logic [DB-1:0] cl_col_s [0:DS];
	logic [DB-1:0] cl_row_s [0:DS];

	logic [KW-1:0] ku_d, kv_d, au_d, av_d;

	always_comb begin
		ku_d = u_s2[SW-1:tsm_pkg::FRAC_SHIFT];
		kv_d = v_s2[SW-1:tsm_pkg::FRAC_SHIFT];
		au_d = ku_d[KW-1] ? (~ku_d + KW'(1)) : ku_d;
		av_d = kv_d[KW-1] ? (~kv_d + KW'(1)) : kv_d;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_rem_s[0]  <= '0;
			v_rem_s[0]  <= '0;
			u_mag_s[0]  <= MW'(au_d);
			v_mag_s[0]  <= MW'(av_d);
			u_neg_s[0]  <= ku_d[KW-1];
			v_neg_s[0]  <= kv_d[KW-1];
			cl_col_s[0] <= clamp_ix(ku_d[KW-1], MW'(au_d), w_n);
			cl_row_s[0] <= clamp_ix(kv_d[KW-1], MW'(av_d), h_n);
		end
	end

	// remainder stages: restoring division, DIV_STEPS bits each
	for (genvar gj = 0; gj < DS; gj++) begin : g_div
		logic [RW-1:0] ur_d, vr_d;
		logic [MW-1:0] um_d, vm_d;

		always_comb begin
			ur_d = u_rem_s[gj];
			vr_d = v_rem_s[gj];
			um_d = u_mag_s[gj];
			vm_d = v_mag_s[gj];
			for (int i = 0; i < tsm_pkg::DIV_STEPS; i++) begin
				ur_d = rem_step(ur_d, um_d[MW-1], m_u);
				vr_d = rem_step(vr_d, vm_d[MW-1], m_v);
				um_d = um_d << 1;
				vm_d = vm_d << 1;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				u_rem_s[gj+1]  <= ur_d;
				v_rem_s[gj+1]  <= vr_d;
				u_mag_s[gj+1]  <= um_d;
				v_mag_s[gj+1]  <= vm_d;
				u_neg_s[gj+1]  <= u_neg_s[gj];
				v_neg_s[gj+1]  <= v_neg_s[gj];
				cl_col_s[gj+1] <= cl_col_s[gj];
				cl_row_s[gj+1] <= cl_row_s[gj];
			end
		end
	end

	// fold stage: negative wrap, then mirror reflection
	function automatic logic [DB-1:0] fold_ix(input logic neg, input logic [RW-1:0] rem,
			input logic [RW-1:0] m, input logic [NW-1:0] n, input logic mir);
		logic [RW-1:0] t;
		t = (neg && (rem != '0)) ? (m - rem) : rem;
		if (mir && (t >= RW'(n)))
			t = m - RW'(1) - t;
		return DB'(t);
	endfunction

	// stage numbers below hold for the default coordinate width
	logic [DB-1:0] col_s8, row_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (mode == tsm_pkg::MODE_CLAMP) begin
				col_s8 <= cl_col_s[DS];
				row_s8 <= cl_row_s[DS];
			end else begin
				col_s8 <= fold_ix(u_neg_s[DS], u_rem_s[DS], m_u, w_n, mirror);
				row_s8 <= fold_ix(v_neg_s[DS], v_rem_s[DS], m_v, h_n, mirror);
			end
		end
	end

	// texel store: writes and reads at the same stage keep item order
	logic [31:0]   texel_mem [DEPTH];
	logic [31:0]   texel_s9;
	logic [AW-1:0] raddr_d;

	assign raddr_d = AW'(32'(row_s8) * 32'(MAX_DIM) + 32'(col_s8));

	always_ff @(posedge clk) begin
		if (adv) begin
			if (vld_s[MS] && wen_s[MS])
				texel_mem[waddr_s[MS]] <= wdata_s[MS];
			texel_s9 <= texel_mem[raddr_d];
		end
	end

	// alpha scale per channel, truncating
	logic [31:0] pixel_d, pixel_s10;

	always_comb begin
		logic [16:0] prod;
		pixel_d = '0;
		for (int c = 0; c < 4; c++) begin
			prod = {9'b0, texel_s9[c*8 +: 8]} * {8'b0, alpha};
			pixel_d[c*8 +: 8] = prod[15:8];
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			pixel_s10 <= pixel_d;
	end

	assign out_valid  = vld_s[LS] && shd_s[LS];
	assign pixel_argb = pixel_s10;

endmodule

`default_nettype wire

// ===== hw/rtl/tsm_checker.sv =====
// ----------------------------------------------------------------------------
// Texture sampler port checker
// Watches the item channels of the sampler top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "texture_sampler_tile_modes_defines.svh"

module tsm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] pixel_argb
);

	// a stalled result holds
	`TSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_argb))

	// input is held back only by a stalled result
	`TSM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

	// a stalled result always freezes the input side
	`TSM_ASSERT_NOW(a_stall_prop, out_valid && out_stall, in_stall)

endmodule

bind texture_sampler_tile_modes tsm_checker u_tsm_checker (.*);

`default_nettype wire
